### rtl/core/tbfc_pkg.sv
// Shared types, constants and codes for the token bus frame checker.
`timescale 1ns / 1ps

package tbfc_pkg;

    localparam int MAX_FRAME_LEN = 256;
    localparam int CNT_W = $clog2(MAX_FRAME_LEN + 2);
    localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0] MIN_LEN_FLOOR = 8'd7;
    localparam logic [5:0] SECT_MAX = 6'd63;

    localparam logic [2:0] ERR_OK = 3'd0;
    localparam logic [2:0] ERR_SHORT = 3'd1;
    localparam logic [2:0] ERR_START = 3'd2;
    localparam logic [2:0] ERR_CRC = 3'd3;
    localparam logic [2:0] ERR_LONG = 3'd4;

    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_DELIM = 2'd1;
    localparam logic [1:0] REG_MIN_LEN = 2'd2;

    localparam logic [1:0] SCAN_SEEK = 2'd0;
    localparam logic [1:0] SCAN_NODE = 2'd1;
    localparam logic [1:0] SCAN_BODY = 2'd2;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] delimiter_byte;
        logic [7:0] min_frame_len;
    } cfg_t;

    typedef struct packed {
        logic       frame_valid;
        logic [2:0] error_code;
        logic [7:0] source_node;
        logic [7:0] next_master;
        logic [7:0] add_node;
        logic [7:0] remove_node;
        logic       has_payload;
        logic [5:0] section_count;
        logic       is_token;
        logic       is_presence;
        logic [8:0] frame_length;
    } verdict_t;

endpackage

### rtl/core/tbfc_crc.sv
// One byte step of the reflected CRC-16/MODBUS.
`timescale 1ns / 1ps

module tbfc_crc (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);
    import tbfc_pkg::*;

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

### rtl/core/tbfc_tracker.sv
// Per-frame state, payload scanner and verdict logic.
`timescale 1ns / 1ps

module tbfc_tracker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [7:0]         data,
    input  logic               last,
    input  tbfc_pkg::cfg_t     cfg,
    output tbfc_pkg::verdict_t verdict
);
    import tbfc_pkg::*;

    logic [15:0]      crc_reg, crc_next, crc_step;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       dly0_reg, dly0_next, dly1_reg, dly1_next;
    logic [7:0]       hdr_reg [4];
    logic [7:0]       hdr_next [4];
    logic             start_ok_reg, start_ok_next;
    logic [1:0]       mode_reg, mode_next;
    logic [1:0]       body_reg, body_next;
    logic [5:0]       sect_reg, sect_next;
    logic             seen_reg, seen_next;

    logic [7:0]       eff_min;
    logic [CMP_W-1:0] n_cmp, min_cmp;
    logic [5:0]       secs;
    logic             short_len, long_len, hdr_ok, payload, valid;
    logic [2:0]       err;
    logic [31:0]      sat32;
    logic [1:0]       hdr_idx;

    tbfc_crc u_crc (
        .crc_in  (crc_reg),
        .data    (dly0_reg),
        .crc_out (crc_step)
    );

    always_comb
    begin
        crc_next = (cnt_reg >= CNT_W'(2)) ? crc_step : crc_reg;
        dly0_next = dly1_reg;
        dly1_next = data;
        cnt_next = (cnt_reg <= CNT_W'(MAX_FRAME_LEN)) ? cnt_reg + CNT_W'(1) : cnt_reg;
        start_ok_next = (cnt_reg == '0) ? (data == cfg.start_byte) : start_ok_reg;
        hdr_idx = 2'(cnt_reg - CNT_W'(1));
        for (int i = 0; i < 4; i++)
        begin
            hdr_next[i] = hdr_reg[i];
        end
        if (cnt_reg >= CNT_W'(1) && cnt_reg <= CNT_W'(4))
        begin
            hdr_next[hdr_idx] = data;
        end

        mode_next = mode_reg;
        body_next = body_reg;
        sect_next = sect_reg;
        seen_next = seen_reg;
        if (cnt_reg >= CNT_W'(7))
        begin
            if (dly0_reg == cfg.delimiter_byte)
            begin
                seen_next = 1'b1;
            end
            case (mode_reg)
                SCAN_SEEK:
                begin
                    if (dly0_reg == cfg.delimiter_byte)
                    begin
                        mode_next = SCAN_NODE;
                    end
                end
                SCAN_NODE:
                begin
                    mode_next = SCAN_BODY;
                    body_next = 2'd0;
                end
                default:
                begin
                    if (dly0_reg == cfg.delimiter_byte)
                    begin
                        if (body_reg >= 2'd2 && sect_reg < SECT_MAX)
                        begin
                            sect_next = sect_reg + 6'd1;
                        end
                        mode_next = SCAN_NODE;
                    end
                    else if (body_reg < 2'd2)
                    begin
                        body_next = body_reg + 2'd1;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        eff_min = (cfg.min_frame_len < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : cfg.min_frame_len;
        n_cmp = CMP_W'(cnt_next);
        min_cmp = CMP_W'(eff_min);
        short_len = n_cmp < min_cmp;
        long_len = n_cmp > CMP_W'(MAX_FRAME_LEN);
        if (short_len)
        begin
            err = ERR_SHORT;
        end
        else if (long_len)
        begin
            err = ERR_LONG;
        end
        else if (!start_ok_next)
        begin
            err = ERR_START;
        end
        else if (crc_next != {dly1_reg, data})
        begin
            err = ERR_CRC;
        end
        else
        begin
            err = ERR_OK;
        end
        valid = (err == ERR_OK);
        hdr_ok = !short_len && start_ok_next;
        payload = (n_cmp >= min_cmp + CMP_W'(1)) && seen_next;

        secs = sect_next;
        if (mode_next == SCAN_BODY && body_next >= 2'd2 && secs < SECT_MAX)
        begin
            secs = secs + 6'd1;
        end
        if (short_len)
        begin
            secs = 6'd0;
        end

        sat32 = long_len ? 32'(MAX_FRAME_LEN) : 32'(cnt_next);

        verdict.frame_valid = valid;
        verdict.error_code = err;
        verdict.source_node = hdr_ok ? hdr_next[0] : 8'd0;
        verdict.next_master = hdr_ok ? hdr_next[1] : 8'd0;
        verdict.add_node = hdr_ok ? hdr_next[2] : 8'd0;
        verdict.remove_node = hdr_ok ? hdr_next[3] : 8'd0;
        verdict.has_payload = payload;
        verdict.section_count = secs;
        verdict.is_token = valid && (hdr_next[1] != 8'd0) && !payload;
        verdict.is_presence = valid && (hdr_next[1] == 8'd0) && (hdr_next[2] == 8'd0)
                              && (hdr_next[3] == 8'd0) && !payload;
        verdict.frame_length = (sat32 > 32'd511) ? 9'd511 : sat32[8:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
            cnt_reg <= '0;
            dly0_reg <= 8'd0;
            dly1_reg <= 8'd0;
            for (int i = 0; i < 4; i++)
            begin
                hdr_reg[i] <= 8'd0;
            end
            start_ok_reg <= 1'b0;
            mode_reg <= SCAN_SEEK;
            body_reg <= 2'd0;
            sect_reg <= 6'd0;
            seen_reg <= 1'b0;
        end
        else if (go)
        begin
            if (last)
            begin
                crc_reg <= CRC_INIT;
                cnt_reg <= '0;
                dly0_reg <= 8'd0;
                dly1_reg <= 8'd0;
                for (int i = 0; i < 4; i++)
                begin
                    hdr_reg[i] <= 8'd0;
                end
                start_ok_reg <= 1'b0;
                mode_reg <= SCAN_SEEK;
                body_reg <= 2'd0;
                sect_reg <= 6'd0;
                seen_reg <= 1'b0;
            end
            else
            begin
                crc_reg <= crc_next;
                cnt_reg <= cnt_next;
                dly0_reg <= dly0_next;
                dly1_reg <= dly1_next;
                for (int i = 0; i < 4; i++)
                begin
                    hdr_reg[i] <= hdr_next[i];
                end
                start_ok_reg <= start_ok_next;
                mode_reg <= mode_next;
                body_reg <= body_next;
                sect_reg <= sect_next;
                seen_reg <= seen_next;
            end
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_FRAME_LEN + 1))
        else $error("Byte counter ran past its saturation point.");

    a_body_bound: assert property (@(posedge clk) disable iff (!rst_n)
        body_reg <= 2'd2)
        else $error("Section body counter ran past two.");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        go && last |=> cnt_reg == '0 && crc_reg == CRC_INIT && sect_reg == 6'd0)
        else $error("Frame state was not cleared after the last item.");
`endif

endmodule

### rtl/core/token_bus_frame_checker_unit.sv
// Top level of the token bus frame checker: input stage, config and verdict register.
//
//  Channel   | Handshake                   | Payload
//  ----------+-----------------------------+----------------------------------------
//  byte      | byte_valid / byte_stall     | data_byte, last_byte
//  verdict   | verdict_valid / verdict_stall | frame_valid ... frame_length
//  config    | cfg_wr_en                   | cfg_index, cfg_data
//
// One item per cycle unless stalled; a verdict is registered when its last item advances.
// The per-byte CRC step and the scanner sit between the input register and the frame state.
// Reset clears all control and frame state; the CRC accumulator restarts at all ones.
// A blocked verdict stalls input only while the next last item waits in the input register.
`timescale 1ns / 1ps

module token_bus_frame_checker_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       verdict_valid,
    input  logic       verdict_stall,
    output logic       frame_valid,
    output logic [2:0] error_code,
    output logic [7:0] source_node,
    output logic [7:0] next_master,
    output logic [7:0] add_node,
    output logic [7:0] remove_node,
    output logic       has_payload,
    output logic [5:0] section_count,
    output logic       is_token,
    output logic       is_presence,
    output logic [8:0] frame_length,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import tbfc_pkg::*;

    cfg_t     cfg_reg;
    logic     in_vld_reg, in_vld_next;
    logic [7:0] in_data_reg;
    logic     in_last_reg;
    logic     advance, accept;
    logic     out_vld_reg, out_vld_next;
    verdict_t out_reg, verdict;

    assign advance = in_vld_reg && (!in_last_reg || !out_vld_reg || !verdict_stall);
    assign byte_stall = in_vld_reg && !advance;
    assign accept = byte_valid && !byte_stall;

    always_comb
    begin
        in_vld_next = accept ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
        if (advance && in_last_reg)
        begin
            out_vld_next = 1'b1;
        end
        else if (!verdict_stall)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    tbfc_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (advance),
        .data    (in_data_reg),
        .last    (in_last_reg),
        .cfg     (cfg_reg),
        .verdict (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte <= 8'd0;
            cfg_reg.delimiter_byte <= 8'd0;
            cfg_reg.min_frame_len <= MIN_LEN_FLOOR;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_START:   cfg_reg.start_byte <= cfg_data;
                REG_DELIM:   cfg_reg.delimiter_byte <= cfg_data;
                REG_MIN_LEN: cfg_reg.min_frame_len <= cfg_data;
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (advance && in_last_reg)
        begin
            out_reg <= verdict;
        end
    end

    assign verdict_valid = out_vld_reg;
    assign frame_valid = out_reg.frame_valid;
    assign error_code = out_reg.error_code;
    assign source_node = out_reg.source_node;
    assign next_master = out_reg.next_master;
    assign add_node = out_reg.add_node;
    assign remove_node = out_reg.remove_node;
    assign has_payload = out_reg.has_payload;
    assign section_count = out_reg.section_count;
    assign is_token = out_reg.is_token;
    assign is_presence = out_reg.is_presence;
    assign frame_length = out_reg.frame_length;

`ifndef SYNTH
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> in_vld_reg && in_last_reg && out_vld_reg && verdict_stall)
        else $error("Input stalled without a blocked verdict.");

    a_verdict_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> out_vld_reg)
        else $error("A finished frame did not produce a verdict.");

    a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(advance && in_last_reg))
        else $error("A verdict appeared without a finished frame.");
`endif

endmodule
